[hdl/crsh_pkg.sv]
// shared types, widths and a helper function for the closest ray segment hit unit
package crsh_pkg;

    // coordinate, direction and derived arithmetic widths
    localparam int CW   = 32;           // coordinate width, Q16.16
    localparam int FB   = 16;           // fraction bits
    localparam int DW   = FB + 2;       // direction width, Q1.16
    localparam int SW   = CW + 1;       // coordinate difference width
    localparam int PW   = SW + DW;      // cross product term width
    localparam int NW   = PW + 1;       // cross product width
    localparam int TW   = PW + 2;       // divider trial width
    localparam int DSW  = 2 * CW;       // squared distance width
    localparam int CNTW = $clog2(SW + 1);
    localparam int AW   = 4;            // configuration address width
    localparam int PDW  = 32;           // configuration data width

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_BASE_X = 2'd0,
        REG_BASE_Y = 2'd1,
        REG_DIR_X  = 2'd2,
        REG_DIR_Y  = 2'd3
    } t_reg;

    // what the back end has to do with one segment
    typedef enum logic [1:0] {
        K_NONE,
        K_CROSS,
        K_COLL
    } t_kind;

    // back end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DIFF,
        S_SQ,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [CW-1:0] seg_a_x;
        logic signed [CW-1:0] seg_a_y;
        logic signed [CW-1:0] seg_b_x;
        logic signed [CW-1:0] seg_b_y;
        logic                 last_segment;
    } t_seg;

    typedef struct packed {
        logic                 hit_found;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
    } t_hit;

    typedef struct packed {
        logic signed [CW-1:0] base_x;
        logic signed [CW-1:0] base_y;
        logic signed [DW-1:0] dir_x;
        logic signed [DW-1:0] dir_y;
    } t_ray;

    // classified segment passed from front to back
    typedef struct packed {
        t_kind                kind;
        logic                 last;
        logic signed [CW-1:0] p0x;
        logic signed [CW-1:0] p0y;
        logic signed [CW-1:0] p1x;
        logic signed [CW-1:0] p1y;
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        logic [PW-1:0]        num;
        logic [PW-1:0]        den;
    } t_task;

    // point lies on the forward side of the ray base
    function automatic logic in_front(input logic signed [CW-1:0] px,
                                      input logic signed [CW-1:0] py,
                                      input t_ray ray);
        logic dx_pos;
        logic dx_neg;
        logic dy_pos;
        dx_pos = !ray.dir_x[DW-1] && (ray.dir_x != '0);
        dx_neg = ray.dir_x[DW-1];
        dy_pos = !ray.dir_y[DW-1] && (ray.dir_y != '0);
        if (dx_pos) begin
            return $signed(px) >= $signed(ray.base_x);
        end else if (dx_neg) begin
            return $signed(px) <= $signed(ray.base_x);
        end else if (dy_pos) begin
            return $signed(py) >= $signed(ray.base_y);
        end
        return $signed(py) <= $signed(ray.base_y);
    endfunction

endpackage

[hdl/crsh_front.sv]
// front end: three stage pipeline that forms the cross products and classifies each segment
module crsh_front import crsh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ray  i_ray,
    input  logic  i_push,
    input  t_seg  i_seg,
    output logic  o_full,
    output logic  o_task_push,
    output t_task o_task,
    input  logic  i_task_full
);

    logic                 r_v1, r_v2, r_v3;
    t_seg                 r_seg1, r_seg2, r_seg3;
    logic                 r_fa1, r_fa2, r_fa3;
    logic                 r_fe1, r_fe2, r_fe3;
    logic                 r_dz1, r_dz2, r_dz3;
    logic signed [SW-1:0] r_sx1, r_sy1, r_wx1, r_wy1;
    logic signed [SW-1:0] r_sx2, r_sy2, r_sx3, r_sy3;
    logic signed [PW-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [NW-1:0] r_den, r_num;

    logic                 stall;
    logic                 adv;
    logic                 den_zero, num_zero, den_neg, num_neg;
    logic                 hit_pos, hit_neg;
    logic [NW-1:0]        den_mag, num_mag;

    // whole pipeline holds while stage 3 has a segment and the queue is full
    assign stall       = r_v3 && i_task_full;
    assign adv         = !stall;
    assign o_full      = stall;
    assign o_task_push = r_v3 && !i_task_full;

    // stage 1: differences and endpoint side tests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_push) begin
            r_seg1 <= i_seg;
            r_sx1  <= SW'(i_seg.seg_b_x) - SW'(i_seg.seg_a_x);
            r_sy1  <= SW'(i_seg.seg_b_y) - SW'(i_seg.seg_a_y);
            r_wx1  <= SW'(i_seg.seg_a_x) - SW'(i_ray.base_x);
            r_wy1  <= SW'(i_seg.seg_a_y) - SW'(i_ray.base_y);
            r_fa1  <= in_front(i_seg.seg_a_x, i_seg.seg_a_y, i_ray);
            r_fe1  <= in_front(i_seg.seg_b_x, i_seg.seg_b_y, i_ray);
            r_dz1  <= (i_ray.dir_x == '0) && (i_ray.dir_y == '0);
        end
    end

    // stage 2: the four cross product terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_seg2 <= r_seg1;
            r_fa2  <= r_fa1;
            r_fe2  <= r_fe1;
            r_dz2  <= r_dz1;
            r_sx2  <= r_sx1;
            r_sy2  <= r_sy1;
            r_pa   <= PW'(i_ray.dir_x * r_sy1);
            r_pb   <= PW'(i_ray.dir_y * r_sx1);
            r_pc   <= PW'(r_wx1 * i_ray.dir_y);
            r_pd   <= PW'(r_wy1 * i_ray.dir_x);
        end
    end

    // stage 3: denominator and numerator
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_seg3 <= r_seg2;
            r_fa3  <= r_fa2;
            r_fe3  <= r_fe2;
            r_dz3  <= r_dz2;
            r_sx3  <= r_sx2;
            r_sy3  <= r_sy2;
            r_den  <= NW'(r_pa) - NW'(r_pb);
            r_num  <= NW'(r_pc) - NW'(r_pd);
        end
    end

    // classification of the segment against the ray
    always_comb begin
        den_zero = (r_den == '0);
        num_zero = (r_num == '0);
        den_neg  = r_den[NW-1];
        num_neg  = r_num[NW-1];
        hit_pos  = !den_zero && !den_neg && !num_neg && (r_num <= r_den);
        hit_neg  = den_neg && (num_neg || num_zero) && (r_num >= r_den);
        den_mag  = den_neg ? NW'(-r_den) : NW'(r_den);
        num_mag  = den_neg ? NW'(-r_num) : NW'(r_num);

        o_task      = '0;
        o_task.last = r_seg3.last_segment;
        o_task.sx   = r_sx3;
        o_task.sy   = r_sy3;
        o_task.num  = num_mag[PW-1:0];
        o_task.den  = den_mag[PW-1:0];
        o_task.p0x  = r_seg3.seg_a_x;
        o_task.p0y  = r_seg3.seg_a_y;
        o_task.p1x  = r_seg3.seg_b_x;
        o_task.p1y  = r_seg3.seg_b_y;
        o_task.kind = K_NONE;
        if (r_dz3) begin
            o_task.kind = K_NONE;
        end else if (den_zero) begin
            if (num_zero) begin
                if (r_fa3 && r_fe3) begin
                    o_task.kind = K_COLL;
                end else if (r_fa3) begin
                    o_task.kind = K_COLL;
                    o_task.p1x  = i_ray.base_x;
                    o_task.p1y  = i_ray.base_y;
                end else if (r_fe3) begin
                    o_task.kind = K_COLL;
                    o_task.p0x  = r_seg3.seg_b_x;
                    o_task.p0y  = r_seg3.seg_b_y;
                    o_task.p1x  = i_ray.base_x;
                    o_task.p1y  = i_ray.base_y;
                end
            end
        end else if (hit_pos || hit_neg) begin
            o_task.kind = K_CROSS;
        end
    end

endmodule

[hdl/crsh_queue.sv]
// two entry queue of classified segments between front and back
module crsh_queue import crsh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_task o_data,
    output logic  o_empty
);

    t_task      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[hdl/crsh_muldiv.sv]
// bit serial floor(a * n / d) with n <= d, one bit of a per cycle
module crsh_muldiv import crsh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SW-1:0] i_a,
    input  logic [PW-1:0] i_n,
    input  logic [PW-1:0] i_d,
    output logic          o_busy,
    output logic [SW-1:0] o_q
);

    logic [CNTW-1:0] r_cnt;
    logic [SW-1:0]   r_a, r_q;
    logic [PW-1:0]   r_n, r_d, r_r;
    logic [TW-1:0]   trial, d1, d2;
    logic [PW-1:0]   n_r;
    logic [SW-1:0]   n_q;

    assign o_busy = (r_cnt != '0);
    assign o_q    = r_q;

    // one step: double the remainder, add n on a set bit, take out d up to twice
    always_comb begin
        d1    = TW'(r_d);
        d2    = TW'({r_d, 1'b0});
        trial = TW'({r_r, 1'b0}) + (r_a[SW-1] ? TW'(r_n) : '0);
        if (trial >= d2) begin
            n_r = PW'(trial - d2);
            n_q = {r_q[SW-2:0], 1'b0} + SW'(2);
        end else if (trial >= d1) begin
            n_r = PW'(trial - d1);
            n_q = {r_q[SW-2:0], 1'b0} + SW'(1);
        end else begin
            n_r = PW'(trial);
            n_q = {r_q[SW-2:0], 1'b0};
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(SW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    // operands, remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_n <= i_n;
            r_d <= i_d;
            r_r <= '0;
            r_q <= '0;
        end else if (o_busy) begin
            r_a <= {r_a[SW-2:0], 1'b0};
            r_r <= n_r;
            r_q <= n_q;
        end
    end

endmodule

[hdl/crsh_back.sv]
// back end: crossing point, squared distance and running nearest hit
module crsh_back import crsh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ray  i_ray,
    input  t_task i_task,
    input  logic  i_task_valid,
    output logic  o_task_pop,
    output t_hit  o_res,
    output logic  o_res_valid,
    input  logic  i_res_pop
);

    t_state               r_state, n_state;
    t_task                r_task;
    logic signed [CW-1:0] r_cx, r_cy;
    logic                 r_second, r_check;
    logic signed [SW-1:0] r_ddx, r_ddy;
    logic [DSW-1:0]       r_sqx, r_sqy;
    logic                 r_best_v;
    logic signed [CW-1:0] r_best_x, r_best_y;
    logic [DSW-1:0]       r_best_d;
    logic                 r_out_v;
    t_hit                 r_out;

    logic                 div_busy_x, div_busy_y;
    logic [SW-1:0]        q_x, q_y;
    logic [SW-1:0]        mag_sx, mag_sy;
    logic signed [SW:0]   off_x, off_y;
    logic signed [SW:0]   px_full, py_full;
    logic signed [2*SW-1:0] sqx_full, sqy_full;
    logic [DSW:0]         dsum;
    logic [DSW-1:0]       dq;
    logic                 nearer;
    logic                 cand_front;
    logic                 res_free;

    // control strobes
    logic                 take, div_start, div_done, emit;

    assign mag_sx = i_task.sx[SW-1] ? SW'(-i_task.sx) : SW'(i_task.sx);
    assign mag_sy = i_task.sy[SW-1] ? SW'(-i_task.sy) : SW'(i_task.sy);

    crsh_muldiv u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (mag_sx),
        .i_n     (i_task.num),
        .i_d     (i_task.den),
        .o_busy  (div_busy_x),
        .o_q     (q_x)
    );

    crsh_muldiv u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (mag_sy),
        .i_n     (i_task.num),
        .i_d     (i_task.den),
        .o_busy  (div_busy_y),
        .o_q     (q_y)
    );

    // crossing point from the signed offsets
    always_comb begin
        off_x   = r_task.sx[SW-1] ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
        off_y   = r_task.sy[SW-1] ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
        px_full = (SW + 1)'(r_task.p0x) + off_x;
        py_full = (SW + 1)'(r_task.p0y) + off_y;
    end

    // distance compare against the kept hit
    always_comb begin
        sqx_full   = r_ddx * r_ddx;
        sqy_full   = r_ddy * r_ddy;
        dsum       = (DSW + 1)'(r_sqx) + (DSW + 1)'(r_sqy);
        dq         = dsum[DSW] ? '1 : dsum[DSW-1:0];
        nearer     = !r_best_v || (dq < r_best_d);
        cand_front = in_front(r_cx, r_cy, i_ray);
        res_free   = !r_out_v || i_res_pop;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_task_valid) begin
                    case (i_task.kind)
                        K_CROSS: n_state = S_DIV;
                        K_COLL:  n_state = S_DIFF;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                if (!div_busy_x && !div_busy_y) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_state = (r_check && !cand_front) ? S_DONE : S_SQ;
            end
            S_SQ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = r_second ? S_DIFF : S_DONE;
            end
            S_DONE: begin
                if (!r_task.last || res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        take      = 1'b0;
        div_start = 1'b0;
        div_done  = 1'b0;
        emit      = 1'b0;
        case (r_state)
            S_IDLE: begin
                take      = i_task_valid;
                div_start = i_task_valid && (i_task.kind == K_CROSS);
            end
            S_DIV: begin
                div_done = !div_busy_x && !div_busy_y;
            end
            S_DONE: begin
                emit = r_task.last && res_free;
            end
            default: begin
            end
        endcase
    end

    assign o_task_pop  = take;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_best_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_best_v <= 1'b0;
            end else if (r_state == S_CMP && nearer) begin
                r_best_v <= 1'b1;
            end
            if (emit) begin
                r_out_v <= 1'b1;
            end else if (i_res_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // candidate datapath
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_task   <= i_task;
            r_cx     <= i_task.p0x;
            r_cy     <= i_task.p0y;
            r_second <= (i_task.kind == K_COLL);
            r_check  <= (i_task.kind == K_CROSS);
        end
        if (div_done) begin
            r_cx <= px_full[CW-1:0];
            r_cy <= py_full[CW-1:0];
        end
        if (r_state == S_DIFF) begin
            r_ddx <= SW'(r_cx) - SW'(i_ray.base_x);
            r_ddy <= SW'(r_cy) - SW'(i_ray.base_y);
        end
        if (r_state == S_SQ) begin
            r_sqx <= sqx_full[DSW-1:0];
            r_sqy <= sqy_full[DSW-1:0];
        end
        if (r_state == S_CMP) begin
            if (nearer) begin
                r_best_x <= r_cx;
                r_best_y <= r_cy;
                r_best_d <= dq;
            end
            if (r_second) begin
                r_cx     <= r_task.p1x;
                r_cy     <= r_task.p1y;
                r_second <= 1'b0;
                r_check  <= 1'b0;
            end
        end
        if (emit) begin
            r_out.hit_found <= r_best_v;
            r_out.hit_x     <= r_best_v ? r_best_x : '0;
            r_out.hit_y     <= r_best_v ? r_best_y : '0;
        end
    end

endmodule

[hdl/closest_ray_segment_hit_unit.sv]
// top level of the closest ray segment hit unit
//
// Segments of Q16.16 coordinates enter on a queue style port: one transfer
// when push is high and full is low. The ray base and direction are set
// through the APB registers; the user must set them only while the unit is
// idle, and the unit has no check for this. pready is tied high. On each
// segment marked last_segment one result (hit_found, hit_x, hit_y) appears
// on the output queue port; it is taken by a transfer when pop is high and
// empty is low. The nearest hit is cleared when the result is produced. A
// three stage front pipeline forms the cross products and classifies the
// segment; a two entry queue feeds the back end, which works one segment
// at a time. The back end takes a miss through IDLE and DONE, a collinear
// segment through DIFF, SQ and CMP for each of its two candidates, and a
// crossing through DIV, where the 33 step bit serial multiply-divide finds
// the point. Reset clears the queues and the kept hit and loads base 0,
// direction (1.0, 0). A result left waiting stalls the back end only at
// the next last segment; the front keeps accepting until the queue fills.
module closest_ray_segment_hit_unit import crsh_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [AW-1:0]  paddr,
    input  logic [PDW-1:0] pwdata,
    output logic [PDW-1:0] prdata,
    output logic           pready,
    input  logic           push,
    output logic           full,
    input  t_seg           i_seg,
    output logic           empty,
    input  logic           pop,
    output t_hit           o_hit
);

    t_ray  r_ray;
    t_reg  reg_sel;
    logic  cfg_wr;
    logic  task_push, task_full, task_pop, task_empty;
    t_task task_in, task_out;
    logic  res_valid;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray.base_x <= '0;
            r_ray.base_y <= '0;
            r_ray.dir_x  <= DW'(1 << FB);
            r_ray.dir_y  <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_BASE_X: r_ray.base_x <= pwdata[CW-1:0];
                REG_BASE_Y: r_ray.base_y <= pwdata[CW-1:0];
                REG_DIR_X:  r_ray.dir_x  <= pwdata[DW-1:0];
                REG_DIR_Y:  r_ray.dir_y  <= pwdata[DW-1:0];
                default: begin
                end
            endcase
        end
    end

    // configuration register reads
    always_comb begin
        case (reg_sel)
            REG_BASE_X: prdata = PDW'(r_ray.base_x);
            REG_BASE_Y: prdata = PDW'(r_ray.base_y);
            REG_DIR_X:  prdata = PDW'(r_ray.dir_x);
            REG_DIR_Y:  prdata = PDW'(r_ray.dir_y);
            default:    prdata = '0;
        endcase
    end

    crsh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ray       (r_ray),
        .i_push      (push),
        .i_seg       (i_seg),
        .o_full      (full),
        .o_task_push (task_push),
        .o_task      (task_in),
        .i_task_full (task_full)
    );

    crsh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (task_push),
        .i_data  (task_in),
        .o_full  (task_full),
        .i_pop   (task_pop),
        .o_data  (task_out),
        .o_empty (task_empty)
    );

    crsh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ray        (r_ray),
        .i_task       (task_out),
        .i_task_valid (!task_empty),
        .o_task_pop   (task_pop),
        .o_res        (o_hit),
        .o_res_valid  (res_valid),
        .i_res_pop    (pop)
    );

    assign empty = !res_valid;

endmodule

[hdl/crsh_checker.sv]
// port level checks for the closest ray segment hit unit, bound to the top level
module crsh_checker import crsh_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic empty,
    input logic pop,
    input t_hit o_hit
);

    // a waiting result holds until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_hit)))
        else $error("result changed before transfer");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> empty)
        else $error("result present after reset");

    // a miss carries zero coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_hit.hit_found) |-> (o_hit.hit_x == '0 && o_hit.hit_y == '0))
        else $error("miss with nonzero coordinates");

endmodule

bind closest_ray_segment_hit_unit crsh_checker u_crsh_checker (.*);

[verif/tb_closest_ray_segment_hit_unit.sv]
// testbench for the closest ray segment hit unit: directed table, random segment sets, scoreboard
module tb_closest_ray_segment_hit_unit;
    import crsh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ONE       = 65536;
    localparam int  DRAIN     = 80;
    localparam int  LIMIT     = 1000000;
    localparam int  PHASE_ITM = 86;

    // row of the directed table; known rows carry a typed-in result
    typedef struct {
        t_seg seg;
        bit   known;
        t_hit hit;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [AW-1:0]  paddr;
    logic [PDW-1:0] pwdata;
    logic [PDW-1:0] prdata;
    logic           pready;
    logic           push;
    logic           full;
    t_seg           i_seg;
    logic           empty;
    logic           pop;
    t_hit           o_hit;

    // ray copy and nearest hit tracker
    longint         ray_bx, ray_by, ray_dx, ray_dy;
    bit             near_valid;
    longint         near_x, near_y;
    logic [63:0]    near_dist;

    t_hit           hit_queue[$];
    t_row           rows[$];
    int             fails;
    int             cycle_count;
    int             hold_left;

    closest_ray_segment_hit_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .i_seg   (i_seg),
        .empty   (empty),
        .pop     (pop),
        .o_hit   (o_hit)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit ahead(longint px, longint py);
        if (ray_dx > 0) return px >= ray_bx;
        if (ray_dx < 0) return px <= ray_bx;
        if (ray_dy > 0) return py >= ray_by;
        return py <= ray_by;
    endfunction

    // keep the candidate if strictly nearer
    function automatic void keep_nearer(longint px, longint py);
        logic signed [127:0] ddx;
        logic signed [127:0] ddy;
        logic signed [127:0] dsum;
        logic [63:0]         dq;
        ddx  = px - ray_bx;
        ddy  = py - ray_by;
        dsum = ddx * ddx + ddy * ddy;
        dq   = (dsum[127:64] != '0) ? '1 : dsum[63:0];
        if (!near_valid || dq < near_dist) begin
            near_valid = 1'b1;
            near_x     = px;
            near_y     = py;
            near_dist  = dq;
        end
    endfunction

    function automatic void clear_nearest();
        near_valid = 1'b0;
        near_x     = 0;
        near_y     = 0;
        near_dist  = '1;
    endfunction

    // fold one segment into the nearest hit; returns 1 with a result on last
    function automatic bit fold_segment(input t_seg s, output t_hit res);
        longint ax, ay, ex, ey, sx, sy, wx, wy, den, num, px, py;
        logic signed [127:0] wide;
        bit fa, fe;
        ax = s.seg_a_x; ay = s.seg_a_y;
        ex = s.seg_b_x; ey = s.seg_b_y;
        res = '0;
        if (ray_dx != 0 || ray_dy != 0) begin
            sx  = ex - ax;
            sy  = ey - ay;
            wx  = ax - ray_bx;
            wy  = ay - ray_by;
            den = ray_dx * sy - ray_dy * sx;
            num = wx * ray_dy - wy * ray_dx;
            if (den == 0) begin
                // collinear: endpoints in front, else the base
                if (num == 0) begin
                    fa = ahead(ax, ay);
                    fe = ahead(ex, ey);
                    if (fa && fe) begin
                        keep_nearer(ax, ay);
                        keep_nearer(ex, ey);
                    end else if (fa) begin
                        keep_nearer(ax, ay);
                        keep_nearer(ray_bx, ray_by);
                    end else if (fe) begin
                        keep_nearer(ex, ey);
                        keep_nearer(ray_bx, ray_by);
                    end
                end
            end else begin
                if (den < 0) begin
                    den = -den;
                    num = -num;
                end
                if (num >= 0 && num <= den) begin
                    wide = sx;
                    wide = wide * num / den;
                    px   = ax + longint'(wide);
                    wide = sy;
                    wide = wide * num / den;
                    py   = ay + longint'(wide);
                    if (ahead(px, py))
                        keep_nearer(px, py);
                end
            end
        end
        if (!s.last_segment)
            return 1'b0;
        res.hit_found = near_valid;
        res.hit_x     = near_valid ? near_x[CW-1:0] : '0;
        res.hit_y     = near_valid ? near_y[CW-1:0] : '0;
        clear_nearest();
        return 1'b1;
    endfunction

    function automatic t_seg mk(int ax, int ay, int ex, int ey, bit last);
        t_seg s;
        s.seg_a_x = ax; s.seg_a_y = ay;
        s.seg_b_x = ex; s.seg_b_y = ey;
        s.last_segment = last;
        return s;
    endfunction

    function automatic t_hit mkhit(bit f, int x, int y);
        t_hit h;
        h.hit_found = f; h.hit_x = x; h.hit_y = y;
        return h;
    endfunction

    // append one row to the directed table
    function automatic void add_row(t_seg s, bit known, t_hit h);
        t_row r;
        r.seg   = s;
        r.known = known;
        r.hit   = h;
        rows.insert(rows.size(), r);
    endfunction

    // random gap length: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // apb register write, idle unit only
    task automatic reg_write(t_reg idx, longint val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(idx) << 2;
        pwdata  <= val[31:0];
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE_X: ray_bx = longint'($signed(val[31:0]));
            REG_BASE_Y: ray_by = longint'($signed(val[31:0]));
            REG_DIR_X:  ray_dx = longint'($signed(val[DW-1:0]));
            REG_DIR_Y:  ray_dy = longint'($signed(val[DW-1:0]));
            default: begin
            end
        endcase
    endtask

    task automatic set_ray(longint bx, longint by, longint dx, longint dy);
        reg_write(REG_BASE_X, bx);
        reg_write(REG_BASE_Y, by);
        reg_write(REG_DIR_X, dx);
        reg_write(REG_DIR_Y, dy);
    endtask

    // wait for all results, then let a segment without result finish
    task automatic settle();
        push <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // one segment transfer; the typed result overrides the prediction
    task automatic send(t_seg s, bit known, t_hit typed, bit gaps);
        t_hit res;
        int   g;
        push  <= 1'b1;
        i_seg <= s;
        do @(posedge i_clk); while (full);
        if (fold_segment(s, res))
            hit_queue.insert(hit_queue.size(), known ? typed : res);
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // random segment shaped around the current ray
    function automatic t_seg rand_seg(bit last);
        longint px, py, vx, vy, k;
        int     mode;
        mode = $urandom_range(0, 9);
        k    = longint'($urandom_range(0, 2100)) - 100;
        px   = ray_bx + k * ray_dx;
        py   = ray_by + k * ray_dy;
        vx   = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        vy   = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        case (mode)
            0: return mk($urandom, $urandom, $urandom, $urandom, last);
            1, 2, 3: begin
                // crossing through a point on the ray line
                return mk(int'(px + vx), int'(py + vy),
                          int'(px - vx * $urandom_range(0, 3)),
                          int'(py - vy * $urandom_range(0, 3)), last);
            end
            4, 5: begin
                // collinear span
                k = longint'($urandom_range(0, 2100)) - 100;
                return mk(int'(px), int'(py), int'(ray_bx + k * ray_dx),
                          int'(ray_by + k * ray_dy), last);
            end
            6: return mk(int'(px), int'(py), int'(px), int'(py), last);
            7: return mk(int'(px + ray_dy), int'(py - ray_dx),
                         int'(px + ray_dy + 5 * ray_dx),
                         int'(py - ray_dx + 5 * ray_dy), last);
            default: return mk(int'(ray_bx + vx), int'(ray_by + vy),
                               int'(ray_bx - vy), int'(ray_by + vx), last);
        endcase
    endfunction

    // result side: random pop with one long hold-off, scoreboard compare
    initial begin
        pop = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (hit_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result %0b %h %h",
                                 o_hit.hit_found, o_hit.hit_x, o_hit.hit_y);
                end else begin
                    t_hit exp_hit;
                    exp_hit = hit_queue.pop_front();
                    if (o_hit.hit_found !== exp_hit.hit_found ||
                        o_hit.hit_x !== exp_hit.hit_x || o_hit.hit_y !== exp_hit.hit_y) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch exp %0b %h %h got %0b %h %h",
                                     exp_hit.hit_found, exp_hit.hit_x, exp_hit.hit_y,
                                     o_hit.hit_found, o_hit.hit_x, o_hit.hit_y);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) < 75);
            end
        end
    end

    // stimulus
    initial begin
        longint bxs[8], bys[8], dxs[8], dys[8];
        t_seg   s;
        int     n, len;
        bit     gaps;
        fails = 0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        push = 1'b0; i_seg = '0;
        ray_bx = 0; ray_by = 0; ray_dx = ONE; ray_dy = 0;
        clear_nearest();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset ray: base origin, direction +x
        add_row(mk(ONE, -ONE, ONE, ONE, 1), 1, mkhit(1, ONE, 0));
        add_row(mk(-ONE, -ONE, -ONE, ONE, 1), 1, mkhit(0, 0, 0));
        add_row(mk(2 * ONE, 0, 5 * ONE, 0, 1), 1, mkhit(1, 2 * ONE, 0));
        add_row(mk(-3 * ONE, 0, 4 * ONE, 0, 1), 1, mkhit(1, 0, 0));
        add_row(mk(0, ONE, 9 * ONE, ONE, 1), 1, mkhit(0, 0, 0));
        add_row(mk(7 * ONE, 0, 7 * ONE, 0, 1), 1, mkhit(1, 7 * ONE, 0));
        add_row(mk(5 * ONE, -ONE, 5 * ONE, ONE, 0), 0, '0);
        add_row(mk(2 * ONE, -ONE, 2 * ONE, ONE, 0), 0, '0);
        add_row(mk(3 * ONE, -ONE, 3 * ONE, ONE, 1), 1, mkhit(1, 2 * ONE, 0));
        add_row(mk(ONE, 0, ONE, 5 * ONE, 1), 1, mkhit(1, ONE, 0));
        add_row(mk(ONE, 5 * ONE, ONE, 0, 1), 1, mkhit(1, ONE, 0));
        add_row(mk(-4 * ONE, 0, -ONE, 0, 1), 1, mkhit(0, 0, 0));
        add_row(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0),
                0, '0);
        add_row(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0),
                0, '0);
        add_row(mk(32'h80000000, 0, 32'h7fffffff, 0, 1), 0, '0);
        add_row(mk(3, -ONE, 3, 2 * ONE, 0), 0, '0);
        add_row(mk(3, ONE, 3, -7, 1), 0, '0);
        foreach (rows[i])
            send(rows[i].seg, rows[i].known, rows[i].hit, 1'b1);
        settle();

        // zero direction: everything misses
        set_ray(0, 0, 0, 0);
        send(mk(ONE, -ONE, ONE, ONE, 0), 0, '0, 1'b0);
        send(mk(0, 0, 0, 0, 1), 1, mkhit(0, 0, 0), 1'b0);
        settle();

        // ray settings, extremes among them
        bxs = '{0, 32'sh7fffffff, -32'sh80000000, 0, 12345, 0, 0, 0};
        bys = '{0, -32'sh80000000, 32'sh7fffffff, 0, -98765, 0, 0, 0};
        dxs = '{-ONE, ONE, -ONE, 0, 46341, 0, 0, 0};
        dys = '{ONE, ONE, 0, -ONE, -46341, 0, 0, 0};
        for (int p = 5; p < 8; p++) begin
            bxs[p] = longint'($signed($urandom)) >>> $urandom_range(0, 14);
            bys[p] = longint'($signed($urandom)) >>> $urandom_range(0, 14);
            dxs[p] = longint'($urandom_range(0, 2 * ONE)) - ONE;
            dys[p] = longint'($urandom_range(0, 2 * ONE)) - ONE;
        end

        for (int p = 0; p < 8; p++) begin
            set_ray(bxs[p], bys[p], dxs[p], dys[p]);
            n = 0;
            while (n < PHASE_ITM) begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                   : $urandom_range(1, 6);
                gaps = ($urandom_range(0, 3) != 0);
                // one long receiver hold-off while segments keep coming
                if (p == 4 && n == 0) begin
                    hold_left = 400;
                    gaps = 1'b0;
                    len  = 60;
                end
                for (int j = 0; j < len; j++) begin
                    s = rand_seg(j == len - 1);
                    if (p == 4 && n < 60) s.last_segment = 1'b1;
                    send(s, 1'b0, '0, gaps);
                    n++;
                end
            end
            settle();
        end

        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hdl/crsh_pkg.sv
hdl/crsh_front.sv
hdl/crsh_queue.sv
hdl/crsh_muldiv.sv
hdl/crsh_back.sv
hdl/closest_ray_segment_hit_unit.sv
hdl/crsh_checker.sv
verif/tb_closest_ray_segment_hit_unit.sv
